/* rtl/host_command_decoder_macros.svh */
// ----------------------------------------------------------------------------
// host_command_decoder_macros
// Assertion macros used by the host command decoder top level.
// ----------------------------------------------------------------------------
`ifndef HOST_COMMAND_DECODER_MACROS_SVH
`define HOST_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/hcd_pkg.sv */
// ----------------------------------------------------------------------------
// hcd_pkg
// Types, codes and helper functions of the host command decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

    // frame header codes
    localparam logic [7:0] TYPE_COMMAND = 8'd1;
    localparam logic [7:0] TYPE_WRITE   = 8'd2;
    localparam logic [7:0] TYPE_READ    = 8'd3;

    localparam logic [7:0] SUB_WR_VOLT = 8'd1;
    localparam logic [7:0] SUB_WR_CURR = 8'd2;

    localparam logic [7:0] SUB_STOP         = 8'd0;
    localparam logic [7:0] SUB_RUN_MONITOR  = 8'd1;
    localparam logic [7:0] SUB_RUN_DISPATCH = 8'd2;

    localparam logic [15:0] WORD_ACK      = 16'h0101;
    localparam logic [15:0] WORD_READ_HDR = 16'h0301;

    localparam int VOLT_MIN   = 3000;
    localparam int VOLT_MAX   = 4000;
    localparam int CURR_LIMIT = 1000;

    localparam int IN_W  = 72;
    localparam int OUT_W = 56;

    // microprogram
    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] ADDR_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] ADDR_DISPATCH   = 4'd1;
    localparam logic [PC_W-1:0] ADDR_STATUS     = 4'd2;
    localparam logic [PC_W-1:0] ADDR_READ       = 4'd3;
    localparam logic [PC_W-1:0] ADDR_READ_ACK   = 4'd4;
    localparam logic [PC_W-1:0] ADDR_READ_TABLE = 4'd5;
    localparam logic [PC_W-1:0] ADDR_APPLY      = 4'd6;
    localparam logic [PC_W-1:0] ADDR_ECHO       = 4'd7;
    localparam logic [PC_W-1:0] ADDR_ACK        = 4'd8;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_DISPATCH,
        OP_EXEC,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_STATUS_WR,
        ACT_APPLY
    } act_t;

    typedef enum logic [1:0] {
        SEL_READ_HDR,
        SEL_ACK,
        SEL_ECHO,
        SEL_STATUS
    } sel_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_STATUS,
        CLS_READ,
        CLS_APPLY
    } cls_t;

    // one control word of the microprogram
    typedef struct packed {
        op_t             op;
        act_t            act;
        sel_t            sel;
        logic            last;
        logic            loop;
        logic [PC_W-1:0] next_pc;
    } uword_t;

    // sequencer -> datapath
    typedef struct packed {
        logic load;
        logic emit;
        act_t act;
        sel_t sel;
        logic last;
    } ctrl_t;

    // datapath -> sequencer
    typedef struct packed {
        cls_t cls;
        logic idx_end;
        logic out_free;
    } stat_t;

    localparam int STATUS_RESET_LEN = 12;
    localparam logic [15:0] STATUS_RESET [STATUS_RESET_LEN] = '{
        16'd3805, 16'd5000, 16'd10000, 16'd0, 16'd500, 16'd495,
        16'd505, 16'd1203, 16'd1154, 16'd1256, 16'd0, 16'd0
    };

    function automatic logic [15:0] status_reset_value(input int i);
        logic [15:0] v;
        v = '0;
        if (i < STATUS_RESET_LEN) begin
            v = STATUS_RESET[i];
        end
        return v;
    endfunction

    // sign-magnitude word -> two's complement, clamped to +/-CURR_LIMIT
    function automatic logic signed [10:0] decode_current(input logic [15:0] w);
        logic [14:0] mag;
        logic [10:0] lim;
        mag = w[14:0];
        lim = (mag > 15'(CURR_LIMIT)) ? 11'(CURR_LIMIT) : mag[10:0];
        return w[15] ? -$signed(lim) : $signed(lim);
    endfunction

endpackage

/* rtl/hcd_ucode_rom.sv */
// ----------------------------------------------------------------------------
// hcd_ucode_rom
// Microprogram store: one control word per step address.
// ----------------------------------------------------------------------------
module hcd_ucode_rom (
    input  logic [hcd_pkg::PC_W-1:0] addr,
    output hcd_pkg::uword_t          uword
);
    import hcd_pkg::*;

    always_comb begin
        case (addr)
            ADDR_IDLE:       uword = '{OP_WAIT,     ACT_NONE,      SEL_ACK,      1'b0, 1'b0,
                                       ADDR_DISPATCH};
            ADDR_DISPATCH:   uword = '{OP_DISPATCH, ACT_NONE,      SEL_ACK,      1'b0, 1'b0,
                                       ADDR_IDLE};
            ADDR_STATUS:     uword = '{OP_EXEC,     ACT_STATUS_WR, SEL_ACK,      1'b0, 1'b0,
                                       ADDR_IDLE};
            ADDR_READ:       uword = '{OP_EMIT,     ACT_NONE,      SEL_READ_HDR, 1'b0, 1'b0,
                                       ADDR_READ_ACK};
            ADDR_READ_ACK:   uword = '{OP_EMIT,     ACT_NONE,      SEL_ACK,      1'b0, 1'b0,
                                       ADDR_READ_TABLE};
            // loops on itself until the final table entry has gone out
            ADDR_READ_TABLE: uword = '{OP_EMIT,     ACT_NONE,      SEL_STATUS,   1'b1, 1'b1,
                                       ADDR_IDLE};
            ADDR_APPLY:      uword = '{OP_EXEC,     ACT_APPLY,     SEL_ACK,      1'b0, 1'b0,
                                       ADDR_ECHO};
            ADDR_ECHO:       uword = '{OP_EMIT,     ACT_NONE,      SEL_ECHO,     1'b0, 1'b0,
                                       ADDR_ACK};
            ADDR_ACK:        uword = '{OP_EMIT,     ACT_NONE,      SEL_ACK,      1'b1, 1'b0,
                                       ADDR_IDLE};
            default:         uword = '{OP_EXEC,     ACT_NONE,      SEL_ACK,      1'b0, 1'b0,
                                       ADDR_IDLE};
        endcase
    end

endmodule

/* rtl/hcd_sequencer.sv */
// ----------------------------------------------------------------------------
// hcd_sequencer
// Step counter of the microprogram with dispatch and loop jumps.
// ----------------------------------------------------------------------------
module hcd_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hcd_pkg::stat_t stat,
    output hcd_pkg::ctrl_t ctrl
);
    import hcd_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uword;

    hcd_ucode_rom u_rom (
        .addr  (pc_reg),
        .uword (uword)
    );

    assign in_ready = (uword.op == OP_WAIT);

    always_comb begin
        pc_next   = pc_reg;
        ctrl.load = 1'b0;
        ctrl.emit = 1'b0;
        ctrl.act  = ACT_NONE;
        ctrl.sel  = uword.sel;
        ctrl.last = uword.last && (!uword.loop || stat.idx_end);
        case (uword.op)
            OP_WAIT: begin
                ctrl.load = in_valid;
                if (in_valid) begin
                    pc_next = uword.next_pc;
                end
            end
            OP_DISPATCH: begin
                case (stat.cls)
                    CLS_STATUS: pc_next = ADDR_STATUS;
                    CLS_READ:   pc_next = ADDR_READ;
                    CLS_APPLY:  pc_next = ADDR_APPLY;
                    default:    pc_next = ADDR_IDLE;
                endcase
            end
            OP_EXEC: begin
                ctrl.act = uword.act;
                pc_next  = uword.next_pc;
            end
            OP_EMIT: begin
                ctrl.emit = stat.out_free;
                if (stat.out_free && (!uword.loop || stat.idx_end)) begin
                    pc_next = uword.next_pc;
                end
            end
            default: pc_next = ADDR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ADDR_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* rtl/hcd_datapath.sv */
// ----------------------------------------------------------------------------
// hcd_datapath
// Frame latch, references and flags, status table and output register.
// ----------------------------------------------------------------------------
module hcd_datapath #(
    parameter int STATUS_WORDS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  hcd_pkg::ctrl_t             ctrl,
    output hcd_pkg::stat_t             stat,
    input  logic                       s_tuser,
    input  logic [hcd_pkg::IN_W-1:0]   s_tdata,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic                       m_tlast,
    output logic [hcd_pkg::OUT_W-1:0]  m_tdata
);
    import hcd_pkg::*;

    localparam int IDX_W = (STATUS_WORDS > 1) ? $clog2(STATUS_WORDS) : 1;
    localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;

    // latched beat
    logic        func_reg;
    logic [7:0]  type_reg;
    logic [7:0]  sub_reg;
    logic [15:0] word_a_reg;
    logic [15:0] word_b_reg;
    logic [3:0]  sidx_reg;
    logic [15:0] sval_reg;

    // state
    logic [11:0]        volt_reg;
    logic signed [10:0] active_reg;
    logic signed [10:0] reactive_reg;
    logic               order_reg;
    logic               mode_reg;
    logic [15:0]        stat_tbl_reg [STATUS_WORDS];
    logic [IDX_W-1:0]   idx_reg;

    logic                  m_tvalid_reg;
    logic                  m_tlast_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    logic [EXT_W-1:0] wr_ext;
    logic             wr_ok;
    logic [11:0]      volt_clamped;
    logic             is_stop;
    logic [15:0]      word_mux;

    assign wr_ext  = EXT_W'(sidx_reg);
    assign wr_ok   = (32'(sidx_reg) < 32'(STATUS_WORDS));
    assign is_stop = (type_reg == TYPE_COMMAND) && (sub_reg == SUB_STOP);

    always_comb begin
        if (word_a_reg > 16'(VOLT_MAX)) begin
            volt_clamped = 12'(VOLT_MAX);
        end else if (word_a_reg < 16'(VOLT_MIN)) begin
            volt_clamped = 12'(VOLT_MIN);
        end else begin
            volt_clamped = word_a_reg[11:0];
        end
    end

    always_comb begin
        stat.idx_end  = (idx_reg == IDX_W'(STATUS_WORDS - 1));
        stat.out_free = !m_tvalid_reg || m_tready;
        if (func_reg) begin
            stat.cls = CLS_STATUS;
        end else begin
            case (type_reg)
                TYPE_READ:    stat.cls = CLS_READ;
                TYPE_WRITE:   stat.cls = (sub_reg == SUB_WR_VOLT || sub_reg == SUB_WR_CURR)
                                         ? CLS_APPLY : CLS_NONE;
                TYPE_COMMAND: stat.cls = (sub_reg == SUB_STOP || sub_reg == SUB_RUN_MONITOR
                                          || sub_reg == SUB_RUN_DISPATCH)
                                         ? CLS_APPLY : CLS_NONE;
                default:      stat.cls = CLS_NONE;
            endcase
        end
    end

    always_comb begin
        case (ctrl.sel)
            SEL_READ_HDR: word_mux = WORD_READ_HDR;
            SEL_ACK:      word_mux = WORD_ACK;
            SEL_ECHO:     word_mux = {type_reg, sub_reg};
            SEL_STATUS:   word_mux = stat_tbl_reg[idx_reg];
            default:      word_mux = WORD_ACK;
        endcase
    end

    // beat latch and output payload
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            func_reg   <= s_tuser;
            type_reg   <= s_tdata[7:0];
            sub_reg    <= s_tdata[15:8];
            word_a_reg <= s_tdata[31:16];
            word_b_reg <= s_tdata[47:32];
            sidx_reg   <= s_tdata[51:48];
            sval_reg   <= s_tdata[67:52];
        end
        if (ctrl.emit) begin
            m_tlast_reg <= ctrl.last;
            m_tdata_reg <= {3'b000, is_stop, mode_reg, order_reg, reactive_reg,
                            active_reg, volt_reg, word_mux};
        end
    end

    // control state, references and status table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            volt_reg     <= 12'(VOLT_MIN);
            active_reg   <= '0;
            reactive_reg <= '0;
            order_reg    <= 1'b0;
            mode_reg     <= 1'b0;
            for (int i = 0; i < STATUS_WORDS; i++) begin
                stat_tbl_reg[i] <= status_reset_value(i);
            end
        end else begin
            if (ctrl.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (ctrl.load) begin
                idx_reg <= '0;
            end else if (ctrl.emit && ctrl.sel == SEL_STATUS) begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (ctrl.act == ACT_STATUS_WR && wr_ok) begin
                stat_tbl_reg[wr_ext[IDX_W-1:0]] <= sval_reg;
            end

            if (ctrl.act == ACT_APPLY) begin
                case (type_reg)
                    TYPE_WRITE: begin
                        if (sub_reg == SUB_WR_VOLT) begin
                            volt_reg     <= volt_clamped;
                            reactive_reg <= decode_current(word_b_reg);
                        end else if (sub_reg == SUB_WR_CURR) begin
                            active_reg   <= decode_current(word_a_reg);
                            reactive_reg <= decode_current(word_b_reg);
                        end
                    end
                    TYPE_COMMAND: begin
                        case (sub_reg)
                            SUB_STOP: begin
                                order_reg <= 1'b0;
                            end
                            SUB_RUN_MONITOR: begin
                                order_reg <= 1'b1;
                                mode_reg  <= 1'b0;
                            end
                            SUB_RUN_DISPATCH: begin
                                order_reg <= 1'b1;
                                mode_reg  <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/host_command_decoder.sv */
// Host command decoder. Takes one host frame or status-table write per input
// beat and answers on the output stream with the response words of that frame,
// tlast on the final word. A read frame streams 0x0301, 0x0101 and the
// STATUS_WORDS status entries; a write or command frame updates the references
// or run flags and answers with its echo word and 0x0101; unknown frames and
// status writes answer nothing. Every output beat also carries the references
// and flags as they stand after the frame. One frame is handled at a time:
// a microprogram steps once per cycle, except that an emit step waits while
// the output stream stalls, and no new beat is taken until it is back at its
// wait step. The output register lets a finished word wait while the next
// step proceeds up to its following emit.
// ----------------------------------------------------------------------------
// host_command_decoder
// Top level: microcoded sequencer driving the frame datapath.
// ----------------------------------------------------------------------------
`include "host_command_decoder_macros.svh"

module host_command_decoder #(
    parameter int STATUS_WORDS = 12     // status table depth, 1..32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] cmd_type, [15:8] cmd_sub, [31:16] word_a, [47:32] word_b,
    // [51:48] status_index, [67:52] status_value, [71:68] zero
    input  logic [71:0] s_tdata,
    // [0] func: 0 host frame, 1 status table write
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] resp_word, [27:16] dc_voltage_ref, [38:28] active_current_ref,
    // [49:39] reactive_current_ref, [50] run_order, [51] run_mode,
    // [52] startup_clear, [55:53] zero
    output logic [55:0] m_tdata,
    // resp_last
    output logic        m_tlast
);
    import hcd_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // step counter + control store
    hcd_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // beat latch, state registers, status table, output register
    hcd_datapath #(
        .STATUS_WORDS (STATUS_WORDS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tdata  (m_tdata)
    );

    // an accepted beat always moves the sequencer off its wait step
    `HCD_ASSERT_NEXT(a_accept_leaves_wait, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // voltage reference stays inside its clamp window
    `HCD_ASSERT_NOW(a_volt_in_range, aclk, aresetn, m_tvalid,
        m_tdata[27:16] >= 12'd3000 && m_tdata[27:16] <= 12'd4000)

    // active current reference stays inside +/-1000
    `HCD_ASSERT_NOW(a_active_in_range, aclk, aresetn, m_tvalid,
        $signed(m_tdata[38:28]) >= -11'sd1000 && $signed(m_tdata[38:28]) <= 11'sd1000)

endmodule
